// ----- design/b6rm_pkg.sv -----
// Package for the base-6 to radix-m converter.
// Holds the sequencer state type, radix and character constants and the digit-to-ASCII map.
// No dependencies.
`timescale 1ns / 1ps

package b6rm_pkg;

	// Source radix and limits of the output radix
	localparam int unsigned SRC_RADIX  = 6;
	localparam int unsigned RADIX_W    = 5;
	localparam int unsigned RADIX_MIN  = 2;
	localparam int unsigned RADIX_MAX  = 20;
	localparam int unsigned RADIX_RST  = 10;
	localparam int unsigned DEC_BASE   = 10;

	// Default sizing
	localparam int unsigned VALUE_LIMIT_DEF    = 1000000;
	localparam int unsigned MAX_OUT_DIGITS_DEF = 20;

	// ASCII bases
	localparam logic [6:0] CHAR_ZERO  = 7'h30;
	localparam logic [6:0] CHAR_ALPHA = 7'h41;

	// Sequencer states
	typedef enum logic [2:0] {
		S_ACC,   // taking digits
		S_MUL,   // dividend times reciprocal
		S_QR,    // quotient estimate times radix
		S_REM,   // remainder, correction, buffer write
		S_RD,    // buffer read issued
		S_LD,    // load character into output register
		S_ERR    // load error word
	} state_t;

	// Digit value 0..19 to ASCII '0'-'9', 'A'-'J'
	function automatic logic [6:0] char_of(input logic [RADIX_W-1:0] d);
		logic [6:0] d7;
		d7 = {2'b00, d};
		if (d7 < 7'(DEC_BASE)) begin
			return CHAR_ZERO + d7;
		end else begin
			return CHAR_ALPHA + (d7 - 7'(DEC_BASE));
		end
	endfunction

endpackage

// ----- design/b6rm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module b6rm_ram #(
	parameter int unsigned WIDTH  = 5,
	parameter int unsigned DEPTH  = 20,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/base6_to_radix_m_converter_top.sv -----
// A digit without the last mark is taken in S_ACC; the input is ready again next cycle.
// A last digit: per output digit, S_MUL, S_QR and S_REM use the shared reciprocal multiplier,
// then each character is read back from the remainder buffer in S_RD and S_LD
// (S_LD waits under backpressure). An overflowed number loads its error word in S_ERR.
// Reset (arst_n low, asynchronous): sequencer idle, value and overflow cleared, radix 10,
// no word on the output. The remainder buffer is not cleared.
`timescale 1ns / 1ps

module base6_to_radix_m_converter_top
	import b6rm_pkg::*;
#(
	parameter int unsigned VALUE_LIMIT    = VALUE_LIMIT_DEF,
	parameter int unsigned MAX_OUT_DIGITS = MAX_OUT_DIGITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration: out_radix
	input  logic               cfg_we,
	input  logic [RADIX_W-1:0] cfg_wdata,
	// input stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [2:0] digit, [7:3] zero
	input  logic               s_tlast,   // final_digit
	// output stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,   // [6:0] out_char, [7] zero
	output logic               m_tlast,   // end_of_run
	output logic               m_tuser    // [0] too_large
);

	localparam int unsigned LIM_W = (VALUE_LIMIT > 1) ? $clog2(VALUE_LIMIT) : 1;
	localparam int unsigned ACC_W = (LIM_W > RADIX_W) ? LIM_W : RADIX_W;
	localparam int unsigned MUL_W = ACC_W + 3;
	localparam int unsigned RCP_W = ACC_W + RADIX_W;
	localparam int unsigned PRD_W = ACC_W + RCP_W;
	localparam int unsigned CNT_W = $clog2(MAX_OUT_DIGITS + 1);
	localparam int unsigned AW    = (MAX_OUT_DIGITS > 1) ? $clog2(MAX_OUT_DIGITS) : 1;

	state_t state_q, state_nx;

	logic [RADIX_W-1:0] radix_cfg_q;
	logic [RADIX_W-1:0] radix_eff;
	logic [ACC_W-1:0]   acc_q;
	logic               ovf_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [AW-1:0]      idx_q;
	logic [PRD_W-1:0]   prod_q;
	logic [ACC_W-1:0]   quo_q;
	logic [ACC_W-1:0]   qr_q;

	logic               out_valid_q;
	logic [6:0]         out_char_q;
	logic               out_last_q;
	logic               out_err_q;

	logic [RCP_W-1:0]   recip_tab [32];

	logic               in_acc;
	logic [MUL_W-1:0]   acc_ext;
	logic [MUL_W-1:0]   acc_mul6;
	logic               hit_limit;
	logic               ovf_nx;
	logic [ACC_W-1:0]   acc_nx;
	logic [ACC_W-1:0]   quo_est;
	logic [ACC_W+RADIX_W-1:0] qr_full;
	logic [ACC_W-1:0]   rem_est;
	logic               rem_fix;
	logic [ACC_W-1:0]   rem_val;
	logic [ACC_W-1:0]   quo_fix;
	logic               div_done;
	logic               out_free;
	logic               ram_we;
	logic               ram_re;
	logic               load_chr;
	logic               load_err;
	logic [RADIX_W-1:0] ram_wdata;
	logic [RADIX_W-1:0] ram_rdata;

	// reciprocal table floor(2^RCP_W / r), built at elaboration
	for (genvar g = 0; g < 32; g++) begin : g_rcp
		if (g >= RADIX_MIN) begin : g_val
			localparam logic [RCP_W-1:0] RV = RCP_W'((64'd1 << RCP_W) / g);
			assign recip_tab[g] = RV;
		end else begin : g_nil
			assign recip_tab[g] = '0;
		end
	end

	// radix clamped to 2..20
	always_comb begin
		radix_eff = radix_cfg_q;
		if (radix_cfg_q < RADIX_W'(RADIX_MIN)) begin
			radix_eff = RADIX_W'(RADIX_MIN);
		end else if (radix_cfg_q > RADIX_W'(RADIX_MAX)) begin
			radix_eff = RADIX_W'(RADIX_MAX);
		end
	end

	// digit accumulation: value*6 + digit, limit check
	assign in_acc    = s_tvalid && s_tready;
	assign acc_ext   = MUL_W'(acc_q);
	assign acc_mul6  = (acc_ext << 2) + (acc_ext << 1) + MUL_W'(s_tdata[2:0]);
	assign hit_limit = acc_mul6 >= MUL_W'(VALUE_LIMIT);
	assign ovf_nx    = ovf_q || hit_limit;
	assign acc_nx    = (ovf_q || hit_limit) ? acc_q : acc_mul6[ACC_W-1:0];

	// division datapath: estimate, back-multiply, correct once
	assign quo_est  = prod_q[PRD_W-1:RCP_W];
	assign qr_full  = (ACC_W+RADIX_W)'(quo_est) * (ACC_W+RADIX_W)'(radix_eff);
	assign rem_est  = acc_q - qr_q;
	assign rem_fix  = rem_est >= ACC_W'(radix_eff);
	assign rem_val  = rem_fix ? (rem_est - ACC_W'(radix_eff)) : rem_est;
	assign quo_fix  = quo_q + ACC_W'(rem_fix);
	assign div_done = (quo_fix == '0) || (cnt_q == CNT_W'(MAX_OUT_DIGITS - 1));
	assign ram_wdata = rem_val[RADIX_W-1:0];

	assign out_free = !out_valid_q || m_tready;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_ACC: begin
				if (in_acc && s_tlast) begin
					state_nx = ovf_nx ? S_ERR : S_MUL;
				end
			end
			S_MUL: state_nx = S_QR;
			S_QR:  state_nx = S_REM;
			S_REM: state_nx = div_done ? S_RD : S_MUL;
			S_RD:  state_nx = S_LD;
			S_LD: begin
				if (out_free) begin
					state_nx = (idx_q == '0) ? S_ACC : S_RD;
				end
			end
			S_ERR: begin
				if (out_free) begin
					state_nx = S_ACC;
				end
			end
			default: state_nx = S_ACC;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		load_chr = 1'b0;
		load_err = 1'b0;
		unique case (state_q)
			S_ACC: s_tready = 1'b1;
			S_REM: ram_we   = 1'b1;
			S_RD:  ram_re   = 1'b1;
			S_LD:  load_chr = out_free;
			S_ERR: load_err = out_free;
			S_MUL, S_QR: ;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_ACC;
			radix_cfg_q <= RADIX_W'(RADIX_RST);
			acc_q       <= '0;
			ovf_q       <= 1'b0;
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				radix_cfg_q <= cfg_wdata;
			end
			// accumulate, start a number
			if (in_acc) begin
				if (s_tlast) begin
					acc_q <= ovf_nx ? '0 : acc_nx;
					ovf_q <= 1'b0;
					cnt_q <= '0;
				end else begin
					acc_q <= acc_nx;
					ovf_q <= ovf_nx;
				end
			end
			// one remainder per pass
			if (ram_we) begin
				acc_q <= div_done ? '0 : quo_fix;
				cnt_q <= cnt_q + CNT_W'(1);
				if (div_done) begin
					idx_q <= cnt_q[AW-1:0];
				end
			end
			if (load_chr && (idx_q != '0)) begin
				idx_q <= idx_q - AW'(1);
			end
			// output word register
			if (load_chr || load_err) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// shared multiplier datapath and output payload
	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			prod_q <= PRD_W'(acc_q) * PRD_W'(recip_tab[radix_eff]);
		end
		if (state_q == S_QR) begin
			quo_q <= quo_est;
			qr_q  <= qr_full[ACC_W-1:0];
		end
		if (load_chr) begin
			out_char_q <= char_of(ram_rdata);
			out_last_q <= idx_q == '0;
			out_err_q  <= 1'b0;
		end else if (load_err) begin
			out_char_q <= '0;
			out_last_q <= 1'b1;
			out_err_q  <= 1'b1;
		end
	end

	// remainder buffer
	b6rm_ram #(
		.WIDTH (RADIX_W),
		.DEPTH (MAX_OUT_DIGITS),
		.ADDR_W(AW)
	) u_buf (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[AW-1:0]),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_char_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_err_q;

`ifndef SYNTH
	// buffer fill never runs past its depth
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_OUT_DIGITS))
		else $error("digit count beyond buffer depth");

	// corrected remainder is a valid digit of the radix
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (rem_val < ACC_W'(radix_eff)))
		else $error("remainder not below radix");

	// an error word is always the last and carries no character
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == 8'd0)))
		else $error("malformed error word");

	// a last digit closes the input until the number is emitted
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("input open straight after last digit");

	// running value stays below the limit
	a_acc_lim: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC) |-> (MUL_W'(acc_q) < MUL_W'(VALUE_LIMIT)))
		else $error("accumulated value at or above limit");
`endif

endmodule

// ----- verif/tb_base6_to_radix_m_converter_top.sv -----
// Self-checking testbench for base6_to_radix_m_converter_top: streams base-6 numbers in,
// predicts the radix-m character words and checks every word that comes out.
// Depends on b6rm_pkg and the converter top level; needs no files or arguments.
`timescale 1ns / 1ps

module tb_base6_to_radix_m_converter_top;
	import b6rm_pkg::*;

	localparam int unsigned RESET_CYCLES = 7;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned ITEM_TARGET = 500;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned LIMIT_NS = 4_000_000;

	// receiver stall patterns
	typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	// one output word as the block should give it
	typedef struct packed {
		logic [6:0] ch;
		logic       eor;
		logic       big;
	} char_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [RADIX_W-1:0] cfg_wdata = '0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = '0;    // [2:0] digit, [7:3] zero
	logic               s_tlast = 1'b0;  // final_digit
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [7:0]         m_tdata;         // [6:0] out_char, [7] zero
	logic               m_tlast;         // end_of_run
	logic               m_tuser;         // [0] too_large

	// predictor state
	logic [19:0]        acc_value = '0;
	logic               acc_over = 1'b0;
	logic [RADIX_W-1:0] radix_reg = RADIX_W'(RADIX_RST);
	char_word_t         pending_chars[$];

	// sender and receiver control
	logic               gaps_on = 1'b0;
	int unsigned        burst_left = 0;
	int unsigned        hold_request = 0;
	int unsigned        hold_left = 0;
	int unsigned        mode_left = 0;
	int unsigned        tick = 0;
	rx_mode_t           stall_mode = RX_FREE;

	// bookkeeping
	int unsigned        failures = 0;
	int unsigned        items_sent = 0;
	int unsigned        numbers_done = 0;
	int unsigned        words_checked = 0;
	int unsigned        overflow_words = 0;
	int unsigned        radix_writes = 0;

	base6_to_radix_m_converter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	always #2 clk = ~clk;

	// Fold one base-6 digit into the running value; on the last digit queue the characters
	function automatic void accumulate_and_convert(input logic [2:0] dg, input logic fin);
		int unsigned nxt;
		int unsigned r;
		int unsigned v;
		int unsigned cnt;
		logic [4:0]  rems [MAX_OUT_DIGITS_DEF];
		char_word_t  w;
		if (!acc_over) begin
			nxt = acc_value * SRC_RADIX + dg;
			if (nxt >= VALUE_LIMIT_DEF) begin
				acc_over = 1'b1;
			end else begin
				acc_value = nxt[19:0];
			end
		end
		if (!fin) return;
		numbers_done++;
		if (acc_over) begin
			w.ch = '0;
			w.eor = 1'b1;
			w.big = 1'b1;
			pending_chars.push_back(w);
		end else begin
			r = radix_reg;
			if (r < RADIX_MIN) r = RADIX_MIN;
			if (r > RADIX_MAX) r = RADIX_MAX;
			v = acc_value;
			cnt = 0;
			if (v == 0) begin
				rems[0] = '0;
				cnt = 1;
			end else begin
				while (v != 0 && cnt < MAX_OUT_DIGITS_DEF) begin
					rems[cnt] = 5'(v % r);
					v = v / r;
					cnt++;
				end
			end
			// most significant remainder first
			for (int i = cnt; i > 0; i--) begin
				w.ch = (rems[i-1] < DEC_BASE) ? CHAR_ZERO + 7'(rems[i-1])
					: CHAR_ALPHA + 7'(rems[i-1] - DEC_BASE);
				w.eor = (i == 1);
				w.big = 1'b0;
				pending_chars.push_back(w);
			end
		end
		acc_value = '0;
		acc_over = 1'b0;
	endfunction

	// Predict on accepted digits first, then check any accepted output word
	always @(posedge clk) begin
		char_word_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) accumulate_and_convert(s_tdata[2:0], s_tlast);
			if (m_tvalid && m_tready) begin
				words_checked++;
				if (m_tuser) overflow_words++;
				if (pending_chars.size() == 0) begin
					$error("unexpected word: out_char %h end_of_run %b too_large %b",
						m_tdata[6:0], m_tlast, m_tuser);
					failures++;
				end else begin
					want = pending_chars.pop_front();
					if (m_tdata[6:0] !== want.ch) begin
						$error("out_char: expected %h, got %h", want.ch, m_tdata[6:0]);
						failures++;
					end
					if (m_tlast !== want.eor) begin
						$error("end_of_run: expected %b, got %b", want.eor, m_tlast);
						failures++;
					end
					if (m_tuser !== want.big) begin
						$error("too_large: expected %b, got %b", want.big, m_tuser);
						failures++;
					end
				end
			end
		end
	end

	// Receiver: long hold-offs on request, otherwise a changing stall pattern
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			if (mode_left == 0) begin
				stall_mode = rx_mode_t'($urandom_range(3));
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			tick++;
			case (stall_mode)
				RX_FREE: m_tready <= 1'b1;
				RX_LIGHT: m_tready <= ($urandom_range(7) != 0);
				RX_HEAVY: m_tready <= ($urandom_range(3) == 0);
				default: m_tready <= (tick[1:0] == 2'b00) || tick[3];
			endcase
		end
	end

	// Offer one digit, with bursty gaps when enabled, and wait for it to be taken
	task automatic send_digit(input logic [2:0] dg, input logic fin);
		int unsigned gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left != 0) burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, dg};
		s_tlast <= fin;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// A well-formed number, optionally with leading zeros or left open
	task automatic send_number(input int unsigned value, input int unsigned lead_zeros,
			input logic closes);
		logic [2:0]  digs[$];
		int unsigned v;
		v = value;
		do begin
			digs.push_front(3'(v % SRC_RADIX));
			v = v / SRC_RADIX;
		end while (v != 0);
		repeat (lead_zeros) digs.push_front(3'd0);
		foreach (digs[i]) send_digit(digs[i], closes && (i == digs.size() - 1));
	endtask

	// Arbitrary digits including six and seven, closed by a final digit
	task automatic send_noise(input int unsigned len);
		for (int i = 0; i < len; i++) send_digit(3'($urandom_range(7)), i == len - 1);
	endtask

	task automatic stop_sending();
		s_tvalid <= 1'b0;
		burst_left = 0;
	endtask

	// Wait for every predicted word, then let the block settle
	task automatic wait_idle();
		@(posedge clk);
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_radix(input logic [RADIX_W-1:0] r);
		cfg_wdata <= r;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		radix_reg = r;
		radix_writes++;
	endtask

	// Reset radix of ten: zero, lone digits six and seven, a two-digit number
	task automatic test_default_radix();
		send_number(0, 0, 1'b1);
		send_digit(3'd7, 1'b1);
		send_digit(3'd6, 1'b1);
		send_number(35, 0, 1'b1);
		stop_sending();
		wait_idle();
	endtask

	// Largest value in binary (twenty characters), then overflow with a digit after it
	task automatic test_value_limits();
		write_radix(5'd2);
		send_number(VALUE_LIMIT_DEF - 1, 0, 1'b1);
		stop_sending();
		wait_idle();
		write_radix(5'd10);
		send_number(VALUE_LIMIT_DEF, 0, 1'b0);
		send_digit(3'd7, 1'b1);
		stop_sending();
		wait_idle();
	endtask

	// Every interesting radix setting, clamped ones included
	task automatic test_radix_sweep();
		logic [RADIX_W-1:0] sweep[$] = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd16, 5'd19, 5'd20,
			5'd21, 5'd31, 5'd10};
		foreach (sweep[k]) begin
			write_radix(sweep[k]);
			send_number((sweep[k] == 5'd20) ? VALUE_LIMIT_DEF - 1
				: $urandom_range(0, VALUE_LIMIT_DEF - 1), 0, 1'b1);
			send_number($urandom_range(0, 500), 0, 1'b1);
			stop_sending();
			wait_idle();
		end
	endtask

	// Receiver holds off while the sender keeps offering, so the input stalls
	task automatic test_backpressure();
		write_radix(5'd2);
		gaps_on = 1'b0;
		hold_request = HOLD_CYCLES;
		for (int n = 0; n < 6; n++) send_number($urandom_range(1, VALUE_LIMIT_DEF - 1), 0, 1'b1);
		stop_sending();
		wait_idle();
	endtask

	// Phases of random numbers under random radix, gaps and stalls
	task automatic test_random();
		int unsigned        phase_end;
		int unsigned        kind;
		logic [RADIX_W-1:0] r;
		while (items_sent < ITEM_TARGET) begin
			case ($urandom_range(5))
				0: r = RADIX_W'($urandom_range(0, 1));
				1: r = RADIX_W'($urandom_range(21, 31));
				default: r = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
			endcase
			write_radix(r);
			gaps_on = ($urandom_range(3) != 0);
			phase_end = items_sent + $urandom_range(20, 60);
			while (items_sent < phase_end) begin
				kind = $urandom_range(9);
				case (kind)
					0: send_number(0, $urandom_range(0, 2), 1'b1);
					1, 2, 3: send_number($urandom_range(0, 215), $urandom_range(0, 1), 1'b1);
					4, 5: send_number($urandom_range(0, VALUE_LIMIT_DEF - 1), 0, 1'b1);
					6: send_number($urandom_range(VALUE_LIMIT_DEF - 100, VALUE_LIMIT_DEF + 100),
						0, 1'b1);
					7: send_number($urandom_range(VALUE_LIMIT_DEF, 1679615), 0, 1'b1);
					default: send_noise($urandom_range(1, 12));
				endcase
				// now and then the sender pauses until the output has drained
				if ($urandom_range(14) == 0) begin
					stop_sending();
					wait_idle();
				end
			end
			stop_sending();
			wait_idle();
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_radix();
		test_value_limits();
		test_radix_sweep();
		test_backpressure();
		test_random();
		stop_sending();
		wait_idle();
		if (pending_chars.size() != 0) begin
			$error("%0d expected words never arrived", pending_chars.size());
			failures++;
		end
		$display("Run covered %0d digits in %0d numbers under %0d radix writes,",
			items_sent, numbers_done, radix_writes);
		$display("checking %0d output words of which %0d were overflow words.",
			words_checked, overflow_words);
		if (failures == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(LIMIT_NS);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
